// ----- src/ipmt_pkg.sv -----
// shared constants, codes and controller-datapath interface types for the int8 tile unit
`timescale 1ns / 1ps
`default_nettype none

package ipmt_pkg;

    // tile shape
    localparam int TILE_ROWS  = 8;
    localparam int TILE_COLS  = 8;
    localparam int TILE_DEPTH = 8;

    localparam int ACC_COUNT = TILE_ROWS * TILE_COLS;
    localparam int LHS_COUNT = TILE_ROWS * TILE_DEPTH;
    localparam int RHS_COUNT = TILE_COLS * TILE_DEPTH;

    // address and counter widths
    localparam int ACC_AW = (ACC_COUNT > 1) ? $clog2(ACC_COUNT) : 1;
    localparam int LHS_AW = (LHS_COUNT > 1) ? $clog2(LHS_COUNT) : 1;
    localparam int RHS_AW = (RHS_COUNT > 1) ? $clog2(RHS_COUNT) : 1;
    localparam int PRE_W  = $clog2(ACC_COUNT + 1);
    localparam int ROW_W  = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
    localparam int COL_W  = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;
    localparam int DEP_W  = (TILE_DEPTH > 1) ? $clog2(TILE_DEPTH) : 1;

    // data widths
    localparam int KIND_W = 2;
    localparam int BYTE_W = 8;
    localparam int ACC_W  = 32;
    localparam int PROD_W = 2 * BYTE_W;
    localparam int DOT_W  = PROD_W + $clog2(TILE_DEPTH);
    localparam int RC_W   = 3;

    // input item kinds
    localparam logic [KIND_W-1:0] KIND_PRELOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LHS     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RHS     = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic              lhs_we;
        logic [LHS_AW-1:0] lhs_waddr;
        logic              rhs_we;
        logic [RHS_AW-1:0] rhs_waddr;
        logic              pre_we;
        logic [ACC_AW-1:0] pre_addr;
        logic              mac_vld;
        logic [LHS_AW-1:0] mac_lhs_addr;
        logic [RHS_AW-1:0] mac_rhs_addr;
        logic [ACC_AW-1:0] mac_acc_idx;
        logic              mac_first;
        logic              mac_last;
        logic              emit_rd;
        logic              emit_ld;
        logic [ACC_AW-1:0] emit_idx;
        logic [RC_W-1:0]   emit_row;
        logic [RC_W-1:0]   emit_col;
        logic              emit_last;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ----- src/ipmt_ctrl.sv -----
// controller: input decode, panel positions, reduction sequencing and result emission
`timescale 1ns / 1ps
`default_nettype none

module ipmt_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_data,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [ipmt_pkg::KIND_W-1:0] i_kind,
    input  wire logic                       i_last_panel,
    input  ipmt_pkg::t_sts                  i_sts,
    output ipmt_pkg::t_cmd                  o_cmd
);
    import ipmt_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_MAC     = 3'd1;
    localparam logic [2:0] ST_DRAIN   = 3'd2;
    localparam logic [2:0] ST_EMIT_RD = 3'd3;
    localparam logic [2:0] ST_EMIT_LD = 3'd4;

    logic [2:0]        r_state,    n_state;
    logic              r_mode;
    logic [LHS_AW-1:0] r_lhs_pos,  n_lhs_pos;
    logic [RHS_AW-1:0] r_rhs_pos,  n_rhs_pos;
    logic [PRE_W-1:0]  r_pre_pos,  n_pre_pos;
    logic              r_last,     n_last;
    logic [DEP_W-1:0]  r_k,        n_k;
    logic [COL_W-1:0]  r_c,        n_c;
    logic [ROW_W-1:0]  r_r,        n_r;
    logic [LHS_AW-1:0] r_lhs_base, n_lhs_base;
    logic [RHS_AW-1:0] r_rhs_base, n_rhs_base;
    logic [ACC_AW-1:0] r_acc_idx,  n_acc_idx;

    logic in_acc;
    logic k_end;
    logic c_end;
    logic r_end;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && (r_state == ST_IDLE);

    assign k_end = (r_k == DEP_W'(TILE_DEPTH - 1));
    assign c_end = (r_c == COL_W'(TILE_COLS - 1));
    assign r_end = (r_r == ROW_W'(TILE_ROWS - 1));

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_lhs_pos  <= '0;
            r_rhs_pos  <= '0;
            r_pre_pos  <= '0;
            r_last     <= 1'b0;
            r_k        <= '0;
            r_c        <= '0;
            r_r        <= '0;
            r_lhs_base <= '0;
            r_rhs_base <= '0;
            r_acc_idx  <= '0;
        end else begin
            r_state    <= n_state;
            r_lhs_pos  <= n_lhs_pos;
            r_rhs_pos  <= n_rhs_pos;
            r_pre_pos  <= n_pre_pos;
            r_last     <= n_last;
            r_k        <= n_k;
            r_c        <= n_c;
            r_r        <= n_r;
            r_lhs_base <= n_lhs_base;
            r_rhs_base <= n_rhs_base;
            r_acc_idx  <= n_acc_idx;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_lhs_pos  = r_lhs_pos;
        n_rhs_pos  = r_rhs_pos;
        n_pre_pos  = r_pre_pos;
        n_last     = r_last;
        n_k        = r_k;
        n_c        = r_c;
        n_r        = r_r;
        n_lhs_base = r_lhs_base;
        n_rhs_base = r_rhs_base;
        n_acc_idx  = r_acc_idx;
        o_cmd      = '0;

        o_cmd.lhs_waddr    = r_lhs_pos;
        o_cmd.rhs_waddr    = r_rhs_pos;
        o_cmd.pre_addr     = r_pre_pos[ACC_AW-1:0];
        o_cmd.mac_lhs_addr = r_lhs_base + LHS_AW'(r_k);
        o_cmd.mac_rhs_addr = r_rhs_base + RHS_AW'(r_k);
        o_cmd.mac_acc_idx  = r_acc_idx;
        o_cmd.mac_first    = (r_k == '0);
        o_cmd.mac_last     = k_end;
        o_cmd.emit_idx     = r_acc_idx;
        o_cmd.emit_row     = RC_W'(r_r);
        o_cmd.emit_col     = RC_W'(r_c);
        o_cmd.emit_last    = (r_acc_idx == ACC_AW'(ACC_COUNT - 1));

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (i_kind)
                        KIND_PRELOAD: begin
                            // saturate once every accumulator is seeded
                            if (r_mode && (r_pre_pos < PRE_W'(ACC_COUNT))) begin
                                o_cmd.pre_we = 1'b1;
                                n_pre_pos    = r_pre_pos + 1'b1;
                            end
                        end
                        KIND_LHS: begin
                            o_cmd.lhs_we = 1'b1;
                            if (r_lhs_pos == LHS_AW'(LHS_COUNT - 1)) begin
                                n_lhs_pos = '0;
                            end else begin
                                n_lhs_pos = r_lhs_pos + 1'b1;
                            end
                        end
                        KIND_RHS: begin
                            o_cmd.rhs_we = 1'b1;
                            if (r_rhs_pos == RHS_AW'(RHS_COUNT - 1)) begin
                                // panel complete: start the reduction step
                                n_rhs_pos  = '0;
                                n_lhs_pos  = '0;
                                n_last     = i_last_panel;
                                n_k        = '0;
                                n_c        = '0;
                                n_r        = '0;
                                n_lhs_base = '0;
                                n_rhs_base = '0;
                                n_acc_idx  = '0;
                                n_state    = ST_MAC;
                            end else begin
                                n_rhs_pos = r_rhs_pos + 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MAC: begin
                // one multiply-add issued per cycle, depth innermost
                o_cmd.mac_vld = 1'b1;
                if (k_end) begin
                    n_k       = '0;
                    n_acc_idx = r_acc_idx + 1'b1;
                    if (c_end) begin
                        n_c        = '0;
                        n_rhs_base = '0;
                        n_r        = r_r + 1'b1;
                        n_lhs_base = r_lhs_base + LHS_AW'(TILE_DEPTH);
                        if (r_end) begin
                            n_r        = '0;
                            n_lhs_base = '0;
                            n_acc_idx  = '0;
                            n_state    = ST_DRAIN;
                        end
                    end else begin
                        n_c        = r_c + 1'b1;
                        n_rhs_base = r_rhs_base + RHS_AW'(TILE_DEPTH);
                    end
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            ST_DRAIN: begin
                // wait for the last accumulator writes
                if (!i_sts.pipe_busy) begin
                    n_state = r_last ? ST_EMIT_RD : ST_IDLE;
                end
            end
            ST_EMIT_RD: begin
                o_cmd.emit_rd = 1'b1;
                n_state       = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_ld = 1'b1;
                    if (o_cmd.emit_last) begin
                        n_acc_idx = '0;
                        n_r       = '0;
                        n_c       = '0;
                        n_pre_pos = '0;
                        n_last    = 1'b0;
                        n_state   = ST_IDLE;
                    end else begin
                        n_acc_idx = r_acc_idx + 1'b1;
                        if (c_end) begin
                            n_c = '0;
                            n_r = r_r + 1'b1;
                        end else begin
                            n_c = r_c + 1'b1;
                        end
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/ipmt_datapath.sv -----
// datapath: panel stores, multiply-accumulate pipeline, accumulator memory and output register
`timescale 1ns / 1ps
`default_nettype none

module ipmt_datapath (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  ipmt_pkg::t_cmd                          i_cmd,
    input  wire logic signed [ipmt_pkg::BYTE_W-1:0] i_operand_byte,
    input  wire logic signed [ipmt_pkg::ACC_W-1:0]  i_preload_word,
    input  wire logic                               i_out_stall,
    output ipmt_pkg::t_sts                          o_sts,
    output logic                                    o_out_valid,
    output logic signed [ipmt_pkg::ACC_W-1:0]       o_result_value,
    output logic [ipmt_pkg::RC_W-1:0]               o_result_row,
    output logic [ipmt_pkg::RC_W-1:0]               o_result_col,
    output logic                                    o_last_result
);
    import ipmt_pkg::*;

    logic signed [BYTE_W-1:0] lhs_mem [LHS_COUNT];
    logic signed [BYTE_W-1:0] rhs_mem [RHS_COUNT];
    logic signed [ACC_W-1:0]  acc_mem [ACC_COUNT];
    logic [ACC_COUNT-1:0]     r_acc_vld;

    // pipeline stage a: operand read
    logic                     r_a_vld;
    logic                     r_a_first;
    logic                     r_a_last;
    logic [ACC_AW-1:0]        r_a_idx;
    logic signed [BYTE_W-1:0] r_lhs_rd;
    logic signed [BYTE_W-1:0] r_rhs_rd;
    // stage b: product
    logic                     r_b_vld;
    logic                     r_b_first;
    logic                     r_b_last;
    logic [ACC_AW-1:0]        r_b_idx;
    logic signed [PROD_W-1:0] r_prod;
    // stage c: dot sum and accumulator read data
    logic                     r_c_vld;
    logic                     r_c_last;
    logic [ACC_AW-1:0]        r_c_idx;
    logic signed [DOT_W-1:0]  r_dot;
    logic signed [ACC_W-1:0]  r_acc_rd;
    logic                     r_acc_rd_ok;

    logic                     acc_we;
    logic [ACC_AW-1:0]        acc_waddr;
    logic signed [ACC_W-1:0]  acc_wdata;
    logic signed [ACC_W-1:0]  acc_old;
    logic                     acc_re;
    logic [ACC_AW-1:0]        acc_raddr;
    logic                     r_out_vld;

    // panel stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.lhs_we) begin
            lhs_mem[i_cmd.lhs_waddr] <= i_operand_byte;
        end
        if (i_cmd.mac_vld) begin
            r_lhs_rd <= lhs_mem[i_cmd.mac_lhs_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rhs_we) begin
            rhs_mem[i_cmd.rhs_waddr] <= i_operand_byte;
        end
        if (i_cmd.mac_vld) begin
            r_rhs_rd <= rhs_mem[i_cmd.mac_rhs_addr];
        end
    end

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_a_vld <= i_cmd.mac_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    // pipeline tags and arithmetic
    always_ff @(posedge i_clk) begin
        r_a_first <= i_cmd.mac_first;
        r_a_last  <= i_cmd.mac_last;
        r_a_idx   <= i_cmd.mac_acc_idx;
        r_b_first <= r_a_first;
        r_b_last  <= r_a_last;
        r_b_idx   <= r_a_idx;
        r_prod    <= r_lhs_rd * r_rhs_rd;
        r_c_last  <= r_b_last;
        r_c_idx   <= r_b_idx;
        if (r_b_vld) begin
            if (r_b_first) begin
                r_dot <= DOT_W'(r_prod);
            end else begin
                r_dot <= r_dot + DOT_W'(r_prod);
            end
        end
    end

    // accumulator port selection
    assign acc_old   = r_acc_rd_ok ? r_acc_rd : '0;
    assign acc_we    = i_cmd.pre_we || (r_c_vld && r_c_last);
    assign acc_waddr = i_cmd.pre_we ? i_cmd.pre_addr : r_c_idx;
    assign acc_wdata = i_cmd.pre_we ? i_preload_word : (acc_old + ACC_W'(r_dot));
    assign acc_re    = i_cmd.emit_rd || (r_b_vld && r_b_last);
    assign acc_raddr = i_cmd.emit_rd ? i_cmd.emit_idx : r_b_idx;

    // accumulator memory
    always_ff @(posedge i_clk) begin
        if (acc_we) begin
            acc_mem[acc_waddr] <= acc_wdata;
        end
        if (acc_re) begin
            r_acc_rd    <= acc_mem[acc_raddr];
            r_acc_rd_ok <= r_acc_vld[acc_raddr];
        end
    end

    // entry valid bits: an entry not valid reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_vld <= '0;
        end else begin
            if (acc_we) begin
                r_acc_vld[acc_waddr] <= 1'b1;
            end
            if (i_cmd.emit_ld) begin
                r_acc_vld[i_cmd.emit_idx] <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit_ld) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_ld) begin
            o_result_value <= acc_old;
            o_result_row   <= i_cmd.emit_row;
            o_result_col   <= i_cmd.emit_col;
            o_last_result  <= i_cmd.emit_last;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_sts.pipe_busy = r_a_vld || r_b_vld || r_c_vld;
    assign o_sts.out_free  = !r_out_vld || !i_out_stall;

endmodule

`default_nettype wire

// ----- src/int8_panel_matmul_tile_unit.sv -----
// top level of the int8 panel tile matrix multiply unit
`timescale 1ns / 1ps
`default_nettype none

// Signed 8x8-bit tile product (8x8 tile, depth 8) with 32-bit wrapping
// accumulators. Preload words (kind 0, accepted only in accumulate mode),
// lhs panel bytes (kind 1) and rhs panel bytes (kind 2) are taken only in
// the idle state. The rhs byte that completes a panel starts a reduction
// step on a single multiply-accumulate unit, rows x cols x depth
// multiply-adds with depth innermost, then a pipeline drain, during which
// input is stalled. If that byte carries last_panel, the 64 accumulators
// are then read out row-major from the accumulator memory, each read and
// then loaded into the output register (held back under output stall), and
// cleared, with input still stalled. There is no clearing pass after reset.
module int8_panel_matmul_tile_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic                               i_cfg_data,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [ipmt_pkg::KIND_W-1:0]        i_kind,
    input  wire logic signed [ipmt_pkg::ACC_W-1:0]  i_preload_word,
    input  wire logic signed [ipmt_pkg::BYTE_W-1:0] i_operand_byte,
    input  wire logic                               i_last_panel,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic signed [ipmt_pkg::ACC_W-1:0]       o_result_value,
    output logic [ipmt_pkg::RC_W-1:0]               o_result_row,
    output logic [ipmt_pkg::RC_W-1:0]               o_result_col,
    output logic                                    o_last_result
);
    import ipmt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // controller
    ipmt_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_last_panel (i_last_panel),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    // datapath
    ipmt_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_operand_byte (i_operand_byte),
        .i_preload_word (i_preload_word),
        .i_out_stall    (i_out_stall),
        .o_sts          (sts),
        .o_out_valid    (o_out_valid),
        .o_result_value (o_result_value),
        .o_result_row   (o_result_row),
        .o_result_col   (o_result_col),
        .o_last_result  (o_last_result)
    );

endmodule

`default_nettype wire
